@@ hw/rtl/fett_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fett_pkg
// Shared constants, register indexes and the control program of the fuzzy
// edge threshold tuner.
// ----------------------------------------------------------------------------
package fett_pkg;

  // Default widths
  localparam int COUNT_WIDTH_DEF = 20;
  localparam int FRAC_BITS_DEF   = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_UPPER = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_UPPER = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  MIN_UPPER_RST = 8'd30;
  localparam logic [CFG_DATA_W-1:0]  MAX_UPPER_RST = 8'd200;
  localparam logic [CFG_DATA_W-1:0]  UPPER_RST_INT = 8'd100;

  // Membership breakpoints (edge pixel counts)
  localparam int BP_W = 15;
  localparam logic [BP_W-1:0] TF_LO   = 15'd18000;
  localparam logic [BP_W-1:0] TF_HI   = 15'd22000;
  localparam logic [BP_W-1:0] F_LO    = 15'd21000;
  localparam logic [BP_W-1:0] F_PEAK  = 15'd22000;
  localparam logic [BP_W-1:0] F_HI    = 15'd23000;
  localparam logic [BP_W-1:0] G_LO    = 15'd22000;
  localparam logic [BP_W-1:0] G_PEAK  = 15'd24000;
  localparam logic [BP_W-1:0] G_HI    = 15'd26000;
  localparam logic [BP_W-1:0] M_LO    = 15'd25000;
  localparam logic [BP_W-1:0] M_PEAK  = 15'd26000;
  localparam logic [BP_W-1:0] M_HI    = 15'd27000;
  localparam logic [BP_W-1:0] TM_LO   = 15'd26000;
  localparam logic [BP_W-1:0] TM_HI   = 15'd29000;

  // Longest flank is 4000 counts: 12 bits
  localparam int FLANK_W = 12;

  // Degree slots
  localparam int DEG_N = 5;
  localparam logic [2:0] D_TOO_FEW  = 3'd0;
  localparam logic [2:0] D_FEW      = 3'd1;
  localparam logic [2:0] D_GOOD     = 3'd2;
  localparam logic [2:0] D_MANY     = 3'd3;
  localparam logic [2:0] D_TOO_MANY = 3'd4;

  // Micro-operations
  localparam logic [3:0] OP_NOP        = 4'd0;
  localparam logic [3:0] OP_FETCH      = 4'd1;
  localparam logic [3:0] OP_PRESET     = 4'd2;
  localparam logic [3:0] OP_FLANK      = 4'd3;
  localparam logic [3:0] OP_WAIT_DEG   = 4'd4;
  localparam logic [3:0] OP_SUM        = 4'd5;
  localparam logic [3:0] OP_ADJ_DIV    = 4'd6;
  localparam logic [3:0] OP_WAIT_ADJ   = 4'd7;
  localparam logic [3:0] OP_CLAMP      = 4'd8;
  localparam logic [3:0] OP_THIRD      = 4'd9;
  localparam logic [3:0] OP_EMIT       = 4'd10;

  // Jump conditions
  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_NO_INPUT = 3'd2;
  localparam logic [2:0] C_OUTSIDE  = 3'd3;
  localparam logic [2:0] C_BUSY     = 3'd4;
  localparam logic [2:0] C_SUM_ZERO = 3'd5;
  localparam logic [2:0] C_OUT_FULL = 3'd6;

  // Program addresses
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] S_FETCH   = 5'd0;
  localparam logic [PC_W-1:0] S_PRESET  = 5'd1;
  localparam logic [PC_W-1:0] S_TF      = 5'd2;
  localparam logic [PC_W-1:0] S_TF_W    = 5'd3;
  localparam logic [PC_W-1:0] S_F_UP    = 5'd4;
  localparam logic [PC_W-1:0] S_F_UP_W  = 5'd5;
  localparam logic [PC_W-1:0] S_F_DN    = 5'd6;
  localparam logic [PC_W-1:0] S_F_DN_W  = 5'd7;
  localparam logic [PC_W-1:0] S_G_UP    = 5'd8;
  localparam logic [PC_W-1:0] S_G_UP_W  = 5'd9;
  localparam logic [PC_W-1:0] S_G_DN    = 5'd10;
  localparam logic [PC_W-1:0] S_G_DN_W  = 5'd11;
  localparam logic [PC_W-1:0] S_M_UP    = 5'd12;
  localparam logic [PC_W-1:0] S_M_UP_W  = 5'd13;
  localparam logic [PC_W-1:0] S_M_DN    = 5'd14;
  localparam logic [PC_W-1:0] S_M_DN_W  = 5'd15;
  localparam logic [PC_W-1:0] S_TM      = 5'd16;
  localparam logic [PC_W-1:0] S_TM_W    = 5'd17;
  localparam logic [PC_W-1:0] S_SUM     = 5'd18;
  localparam logic [PC_W-1:0] S_ADJ     = 5'd19;
  localparam logic [PC_W-1:0] S_ADJ_W   = 5'd20;
  localparam logic [PC_W-1:0] S_CLAMP   = 5'd21;
  localparam logic [PC_W-1:0] S_THIRD   = 5'd22;
  localparam logic [PC_W-1:0] S_EMIT    = 5'd23;
  localparam logic [PC_W-1:0] S_LOOP    = 5'd24;

  // One control word
  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
    logic [BP_W-1:0] lo;
    logic [BP_W-1:0] hi;
    logic            rising;
    logic [2:0]      deg;
  } ucode_t;

  function automatic ucode_t uc(input logic [3:0] op, input logic [2:0] cond,
                                input logic [PC_W-1:0] target,
                                input logic [BP_W-1:0] lo,
                                input logic [BP_W-1:0] hi,
                                input logic rising, input logic [2:0] deg);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.lo     = lo;
    w.hi     = hi;
    w.rising = rising;
    w.deg    = deg;
    return w;
  endfunction

  // Control program ROM
  function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      S_FETCH:   w = uc(OP_FETCH, C_NO_INPUT, S_FETCH, '0, '0, 1'b0, '0);
      S_PRESET:  w = uc(OP_PRESET, C_NEVER, S_FETCH, '0, '0, 1'b0, '0);
      S_TF:      w = uc(OP_FLANK, C_OUTSIDE, S_F_UP, TF_LO, TF_HI, 1'b0, D_TOO_FEW);
      S_TF_W:    w = uc(OP_WAIT_DEG, C_BUSY, S_TF_W, '0, '0, 1'b0, D_TOO_FEW);
      S_F_UP:    w = uc(OP_FLANK, C_OUTSIDE, S_F_DN, F_LO, F_PEAK, 1'b1, D_FEW);
      S_F_UP_W:  w = uc(OP_WAIT_DEG, C_BUSY, S_F_UP_W, '0, '0, 1'b0, D_FEW);
      S_F_DN:    w = uc(OP_FLANK, C_OUTSIDE, S_G_UP, F_PEAK, F_HI, 1'b0, D_FEW);
      S_F_DN_W:  w = uc(OP_WAIT_DEG, C_BUSY, S_F_DN_W, '0, '0, 1'b0, D_FEW);
      S_G_UP:    w = uc(OP_FLANK, C_OUTSIDE, S_G_DN, G_LO, G_PEAK, 1'b1, D_GOOD);
      S_G_UP_W:  w = uc(OP_WAIT_DEG, C_BUSY, S_G_UP_W, '0, '0, 1'b0, D_GOOD);
      S_G_DN:    w = uc(OP_FLANK, C_OUTSIDE, S_M_UP, G_PEAK, G_HI, 1'b0, D_GOOD);
      S_G_DN_W:  w = uc(OP_WAIT_DEG, C_BUSY, S_G_DN_W, '0, '0, 1'b0, D_GOOD);
      S_M_UP:    w = uc(OP_FLANK, C_OUTSIDE, S_M_DN, M_LO, M_PEAK, 1'b1, D_MANY);
      S_M_UP_W:  w = uc(OP_WAIT_DEG, C_BUSY, S_M_UP_W, '0, '0, 1'b0, D_MANY);
      S_M_DN:    w = uc(OP_FLANK, C_OUTSIDE, S_TM, M_PEAK, M_HI, 1'b0, D_MANY);
      S_M_DN_W:  w = uc(OP_WAIT_DEG, C_BUSY, S_M_DN_W, '0, '0, 1'b0, D_MANY);
      S_TM:      w = uc(OP_FLANK, C_OUTSIDE, S_SUM, TM_LO, TM_HI, 1'b1, D_TOO_MANY);
      S_TM_W:    w = uc(OP_WAIT_DEG, C_BUSY, S_TM_W, '0, '0, 1'b0, D_TOO_MANY);
      S_SUM:     w = uc(OP_SUM, C_NEVER, S_FETCH, '0, '0, 1'b0, '0);
      S_ADJ:     w = uc(OP_ADJ_DIV, C_SUM_ZERO, S_CLAMP, '0, '0, 1'b0, '0);
      S_ADJ_W:   w = uc(OP_WAIT_ADJ, C_BUSY, S_ADJ_W, '0, '0, 1'b0, '0);
      S_CLAMP:   w = uc(OP_CLAMP, C_NEVER, S_FETCH, '0, '0, 1'b0, '0);
      S_THIRD:   w = uc(OP_THIRD, C_NEVER, S_FETCH, '0, '0, 1'b0, '0);
      S_EMIT:    w = uc(OP_EMIT, C_OUT_FULL, S_EMIT, '0, '0, 1'b0, '0);
      S_LOOP:    w = uc(OP_NOP, C_ALWAYS, S_FETCH, '0, '0, 1'b0, '0);
      default:   w = uc(OP_NOP, C_ALWAYS, S_FETCH, '0, '0, 1'b0, '0);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fett_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fett_in_if
// Input channel: one edge pixel count per word.
// ----------------------------------------------------------------------------
interface fett_in_if #(
  parameter int COUNT_WIDTH = 20
);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] edge_count;

  modport source (output valid, output edge_count, input ready);
  modport sink   (input valid, input edge_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fett_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fett_out_if
// Result channel: new thresholds and the applied step, one set per word.
// ----------------------------------------------------------------------------
interface fett_out_if #(
  parameter int FRAC_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [FRAC_BITS+7:0]        upper_threshold;
  logic [FRAC_BITS+6:0]        lower_threshold;
  logic signed [FRAC_BITS+1:0] adjustment;

  modport source (output valid, output upper_threshold, output lower_threshold,
                  output adjustment, input ready);
  modport sink   (input valid, input upper_threshold, input lower_threshold,
                  input adjustment, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fuzzy_edge_threshold_tuner_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_edge_threshold_tuner_core
// Fuzzy edge-count controller that steers a Canny threshold pair, upper Q8.F and lower Q7.F.
// ----------------------------------------------------------------------------
// One count word is processed at a time by a 25-step microprogram driving a
// single radix-2 restoring divider; the lower threshold comes from a reciprocal
// multiply. The divider runs once for each membership flank the count falls on
// (zero, one or two) and, unless the degree sum is zero, once more for the
// adjustment, one quotient bit per cycle. A finished result sits in an output
// register, and the next count is taken while it waits; a second result waits
// for the first to drain. The upper threshold resets to 100.0, bounds to 30
// and 200.
module fuzzy_edge_threshold_tuner_core #(
  parameter int COUNT_WIDTH = fett_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = fett_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [fett_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [fett_pkg::CFG_DATA_W-1:0]      cfg_data,
  fett_in_if.sink                                   frame,
  fett_out_if.source                                result
);
  import fett_pkg::*;

  // Derived widths
  localparam int DEG_W  = FRAC_BITS + 1;
  localparam int SUM_W  = FRAC_BITS + 3;
  localparam int LVL_W  = FRAC_BITS + 8;
  localparam int LOW_W  = FRAC_BITS + 7;
  localparam int ADJ_W  = FRAC_BITS + 2;
  localparam int CLP_W  = FRAC_BITS + 10;
  localparam int DW     = (2 * FRAC_BITS + 3 > FRAC_BITS + FLANK_W)
                          ? 2 * FRAC_BITS + 3 : FRAC_BITS + FLANK_W;
  localparam int VW     = FRAC_BITS + 4;
  localparam int QK_SHORT = FRAC_BITS + 1;
  localparam int QW     = QK_SHORT;
  localparam int CNT_W  = $clog2(QK_SHORT + 1);
  localparam logic [DEG_W-1:0] UNIT = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [LVL_W-1:0] RESET_LEVEL = {UPPER_RST_INT, {FRAC_BITS{1'b0}}};
  // Divide by three: ceil(2^(LVL_W+1) / 3), exact for every LVL_W-bit level
  localparam int               THIRD_SH  = LVL_W + 1;
  localparam logic [LVL_W-1:0] THIRD_MUL =
    LVL_W'(((64'd1 << THIRD_SH) + 64'd2) / 64'd3);

  // Sequencer and configuration
  logic [PC_W-1:0]       pc, pc_next;
  ucode_t                word;
  logic                  taken;
  logic [CFG_DATA_W-1:0] min_upper, max_upper;
  logic [LVL_W-1:0]      upper_level;
  logic                  out_full;

  // Datapath
  logic [COUNT_WIDTH-1:0] count;
  logic [DEG_W-1:0]       deg [DEG_N];
  logic [SUM_W-1:0]       deg_sum, mag;
  logic                   negative;
  logic signed [ADJ_W-1:0] adj;
  logic [LOW_W-1:0]       lower;
  logic [LVL_W-1:0]       out_upper;
  logic [LOW_W-1:0]       out_lower;
  logic signed [ADJ_W-1:0] out_adj;
  logic [2*LVL_W-1:0]     third_prod;

  // Divider
  logic             div_start, div_busy;
  logic [DW-1:0]    div_num_in, div_num;
  logic [VW-1:0]    div_den_in, div_den, div_rem;
  logic [QW-1:0]    div_quo;
  logic [CNT_W-1:0] div_cnt;
  logic [VW+1:0]    div_trial;

  // Flank and combine helpers
  logic [COUNT_WIDTH-1:0] lo_ext, hi_ext, dist_full;
  logic [BP_W-1:0]        len_full;
  logic                   outside;
  logic [SUM_W-1:0]       pos, neg, sum_c;
  logic [DEG_W-1:0]       quo_deg;
  logic signed [CLP_W-1:0] lvl, lo_b, hi_b, lvl_lo, lvl_clamped;

  assign word = ucode_word(pc);

  // Flank geometry of the current step
  assign lo_ext    = COUNT_WIDTH'(word.lo);
  assign hi_ext    = COUNT_WIDTH'(word.hi);
  assign outside   = !((count > lo_ext) && (count < hi_ext));
  assign dist_full = word.rising ? count - lo_ext : hi_ext - count;
  assign len_full  = word.hi - word.lo;

  // Weighted numerator and degree sum, in half units
  assign pos   = SUM_W'(deg[D_MANY]) + SUM_W'({deg[D_TOO_MANY], 1'b0})
                 + SUM_W'(deg[D_TOO_MANY]);
  assign neg   = SUM_W'({deg[D_TOO_FEW], 1'b0}) + SUM_W'(deg[D_TOO_FEW])
                 + SUM_W'(deg[D_FEW]);
  assign sum_c = SUM_W'(deg[D_TOO_FEW]) + SUM_W'(deg[D_FEW]) + SUM_W'(deg[D_GOOD])
                 + SUM_W'(deg[D_MANY]) + SUM_W'(deg[D_TOO_MANY]);

  // Saturation: lower bound first, upper bound last
  assign lvl  = $signed({2'b00, upper_level}) + $signed({{8{adj[ADJ_W-1]}}, adj});
  assign lo_b = $signed({2'b00, min_upper, {FRAC_BITS{1'b0}}});
  assign hi_b = $signed({2'b00, max_upper, {FRAC_BITS{1'b0}}});
  assign lvl_lo      = (lvl < lo_b) ? lo_b : lvl;
  assign lvl_clamped = (lvl_lo > hi_b) ? hi_b : lvl_lo;

  // Lower threshold by reciprocal multiply
  assign third_prod = upper_level * THIRD_MUL;

  assign quo_deg = div_quo[DEG_W-1:0];

  // Jump decision
  always_comb begin
    unique case (word.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_INPUT: taken = !frame.valid;
      C_OUTSIDE:  taken = outside;
      C_BUSY:     taken = div_busy;
      C_SUM_ZERO: taken = (deg_sum == '0);
      C_OUT_FULL: taken = out_full;
      default:    taken = 1'b0;
    endcase
    pc_next = taken ? word.target : pc + 1'b1;
  end

  // Divider operand selection
  always_comb begin
    div_start  = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    unique case (word.op)
      OP_FLANK: begin
        div_start  = !outside;
        div_num_in = DW'(dist_full[FLANK_W-1:0]) << FRAC_BITS;
        div_den_in = VW'(len_full[FLANK_W-1:0]);
      end
      OP_ADJ_DIV: begin
        div_start  = (deg_sum != '0);
        div_num_in = DW'(mag) << FRAC_BITS;
        div_den_in = VW'({deg_sum, 1'b0});
      end
      default: begin
      end
    endcase
  end

  assign div_trial = {1'b0, div_rem, div_num[DW-1]} - {2'b00, div_den};

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= S_FETCH;
      out_full    <= 1'b0;
      div_busy    <= 1'b0;
      min_upper   <= MIN_UPPER_RST;
      max_upper   <= MAX_UPPER_RST;
      upper_level <= RESET_LEVEL;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_UPPER: min_upper <= cfg_data;
          REG_MAX_UPPER: max_upper <= cfg_data;
          default: begin
          end
        endcase
      end
      if (word.op == OP_CLAMP) begin
        upper_level <= lvl_clamped[LVL_W-1:0];
      end
      if (word.op == OP_EMIT && !out_full) begin
        out_full <= 1'b1;
      end else if (result.ready) begin
        out_full <= 1'b0;
      end
      if (div_start) begin
        div_busy <= 1'b1;
      end else if (div_busy && div_cnt == CNT_W'(1)) begin
        div_busy <= 1'b0;
      end
    end
  end

  // Divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem <= VW'(div_num_in >> QK_SHORT);
      div_num <= div_num_in << (DW - QK_SHORT);
      div_den <= div_den_in;
      div_quo <= '0;
      div_cnt <= CNT_W'(QK_SHORT);
    end else if (div_busy) begin
      if (!div_trial[VW+1]) begin
        div_rem <= div_trial[VW-1:0];
      end else begin
        div_rem <= {div_rem[VW-2:0], div_num[DW-1]};
      end
      div_num <= div_num << 1;
      div_quo <= {div_quo[QW-2:0], !div_trial[VW+1]};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (word.op)
      OP_FETCH: begin
        if (frame.valid) begin
          count <= frame.edge_count;
        end
      end
      OP_PRESET: begin
        deg[D_TOO_FEW]  <= (count <= COUNT_WIDTH'(TF_LO)) ? UNIT : '0;
        deg[D_FEW]      <= (count == COUNT_WIDTH'(F_PEAK)) ? UNIT : '0;
        deg[D_GOOD]     <= (count == COUNT_WIDTH'(G_PEAK)) ? UNIT : '0;
        deg[D_MANY]     <= (count == COUNT_WIDTH'(M_PEAK)) ? UNIT : '0;
        deg[D_TOO_MANY] <= (count >= COUNT_WIDTH'(TM_HI)) ? UNIT : '0;
      end
      OP_WAIT_DEG: begin
        if (!div_busy) begin
          deg[word.deg] <= quo_deg;
        end
      end
      OP_SUM: begin
        deg_sum  <= sum_c;
        negative <= (neg > pos);
        mag      <= (neg > pos) ? neg - pos : pos - neg;
        adj      <= '0;
      end
      OP_WAIT_ADJ: begin
        if (!div_busy) begin
          adj <= negative ? -$signed(ADJ_W'(quo_deg)) : $signed(ADJ_W'(quo_deg));
        end
      end
      OP_THIRD: begin
        lower <= third_prod[THIRD_SH+LOW_W-1:THIRD_SH];
      end
      OP_EMIT: begin
        if (!out_full) begin
          out_upper <= upper_level;
          out_lower <= lower;
          out_adj   <= adj;
        end
      end
      default: begin
      end
    endcase
  end

  // Ports
  assign frame.ready            = (word.op == OP_FETCH);
  assign result.valid           = out_full;
  assign result.upper_threshold = out_upper;
  assign result.lower_threshold = out_lower;
  assign result.adjustment      = out_adj;

  // Checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (word.op == OP_WAIT_DEG || word.op == OP_WAIT_ADJ))
    else $error("sequencer left a wait step with the divider running");

  a_clamp_bounds: assert property (@(posedge clk) disable iff (rst)
    (word.op == OP_CLAMP && min_upper <= max_upper) |=>
      (upper_level >= {min_upper, {FRAC_BITS{1'b0}}} &&
       upper_level <= {max_upper, {FRAC_BITS{1'b0}}}))
    else $error("upper threshold outside configured bounds");

  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_full) |-> $past(word.op == OP_EMIT))
    else $error("result word raised outside the emit step");

endmodule
`default_nettype wire

@@ tb/tb_fuzzy_edge_threshold_tuner_core.sv @@
// ----------------------------------------------------------------------------
// tb_fuzzy_edge_threshold_tuner_core
// Self-checking bench for the fuzzy edge threshold tuner. A queue of planned
// count words and bound settings feeds a clocked driver, which predicts the
// threshold set of every count word it hands over. A clocked monitor takes
// result words under random stalls and checks each against the oldest
// prediction. Bounds change only while the tuner is drained.
// ----------------------------------------------------------------------------
module tb_fuzzy_edge_threshold_tuner_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fett_pkg::*;

  localparam int CW = COUNT_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint unsigned UNIT = 64'd1 << FB;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_WORDS = 60;

  // Membership breakpoints, counts
  localparam longint unsigned TOO_FEW_LO  = 18000;
  localparam longint unsigned TOO_FEW_HI  = 22000;
  localparam longint unsigned FEW_LO      = 21000;
  localparam longint unsigned FEW_PK      = 22000;
  localparam longint unsigned FEW_HI      = 23000;
  localparam longint unsigned GOOD_LO     = 22000;
  localparam longint unsigned GOOD_PK     = 24000;
  localparam longint unsigned GOOD_HI     = 26000;
  localparam longint unsigned MANY_LO     = 25000;
  localparam longint unsigned MANY_PK     = 26000;
  localparam longint unsigned MANY_HI     = 27000;
  localparam longint unsigned TOO_MANY_LO = 26000;
  localparam longint unsigned TOO_MANY_HI = 29000;

  typedef enum logic [1:0] {PW_COUNT, PW_SETTING, PW_SETTLE} plan_kind_t;

  typedef struct {
    plan_kind_t             kind;
    logic [CW-1:0]          count;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  value;
  } plan_word_t;

  typedef struct packed {
    logic [FB+7:0]        upper;
    logic [FB+6:0]        lower;
    logic signed [FB+1:0] adj;
  } thresholds_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fett_in_if  #(.COUNT_WIDTH(CW)) frame_ch ();
  fett_out_if #(.FRAC_BITS(FB))   result_ch ();

  fuzzy_edge_threshold_tuner_core #(
    .COUNT_WIDTH(CW),
    .FRAC_BITS  (FB)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .frame    (frame_ch),
    .result   (result_ch)
  );

  plan_word_t      frame_plan[$];
  thresholds_t     thresholds_due[$];
  logic [FB+7:0]   tuned_upper;
  logic [7:0]      bound_min;
  logic [7:0]      bound_max;
  bit              failed;
  int              tx_gap;
  int              rx_stall;
  bit              tx_burst;
  bit              rx_burst;
  int              idle_cycles;

  // Clock and reset
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (10) @(posedge clk);
        rst <= 1'b0;
      end
    join_none
  end

  // Membership grades, Q1.FB
  function automatic longint unsigned fall_deg(longint unsigned x, longint unsigned lo,
                                               longint unsigned hi);
    if (x <= lo) return UNIT;
    if (x >= hi) return 0;
    return ((hi - x) * UNIT) / (hi - lo);
  endfunction

  function automatic longint unsigned rise_deg(longint unsigned x, longint unsigned lo,
                                               longint unsigned hi);
    if (x <= lo) return 0;
    if (x >= hi) return UNIT;
    return ((x - lo) * UNIT) / (hi - lo);
  endfunction

  function automatic longint unsigned peak_deg(longint unsigned x, longint unsigned lo,
                                               longint unsigned pk, longint unsigned hi);
    if (x <= lo || x >= hi) return 0;
    if (x == pk) return UNIT;
    if (x < pk) return ((x - lo) * UNIT) / (pk - lo);
    return ((hi - x) * UNIT) / (hi - pk);
  endfunction

  // Next threshold set for one count; advances the tracked upper level
  function automatic thresholds_t next_thresholds(input logic [CW-1:0] cnt);
    longint unsigned x, d_tf, d_f, d_g, d_m, d_tm, pos, neg, sum, mag, q;
    longint          adj, lvl, lo_b, hi_b;
    thresholds_t     t;
    x    = 64'(cnt);
    d_tf = fall_deg(x, TOO_FEW_LO, TOO_FEW_HI);
    d_f  = peak_deg(x, FEW_LO, FEW_PK, FEW_HI);
    d_g  = peak_deg(x, GOOD_LO, GOOD_PK, GOOD_HI);
    d_m  = peak_deg(x, MANY_LO, MANY_PK, MANY_HI);
    d_tm = rise_deg(x, TOO_MANY_LO, TOO_MANY_HI);
    pos  = d_m + 3 * d_tm;
    neg  = 3 * d_tf + d_f;
    sum  = d_tf + d_f + d_g + d_m + d_tm;
    mag  = (neg > pos) ? neg - pos : pos - neg;
    adj  = 0;
    if (sum != 0) begin
      q   = (mag * UNIT) / (2 * sum);
      adj = (neg > pos) ? -longint'(q) : longint'(q);
    end
    // lower bound first, so crossed bounds end at the upper one
    lo_b = longint'(bound_min) * longint'(UNIT);
    hi_b = longint'(bound_max) * longint'(UNIT);
    lvl  = longint'(tuned_upper) + adj;
    if (lvl < lo_b) lvl = lo_b;
    if (lvl > hi_b) lvl = hi_b;
    tuned_upper = lvl[FB+7:0];
    t.upper = tuned_upper;
    t.lower = (FB+7)'(tuned_upper / 3);
    t.adj   = adj[FB+1:0];
    return t;
  endfunction

  // Idle cycles before the next word; bursts run with none
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, 5));
  endfunction

  // Count with a bias: 0 around the good band, 1 high, 2 low
  function automatic logic [CW-1:0] draw_count(int bias);
    longint unsigned knees[13];
    int              r;
    knees = '{18000, 21000, 22000, 23000, 24000, 25000, 26000, 27000, 29000,
              17999, 29001, 21999, 26001};
    r = $urandom_range(0, 99);
    if (r < 10) return CW'($urandom);
    if (r < 25) return CW'(knees[$urandom_range(0, 12)] + $urandom_range(0, 4) - 2);
    case (bias)
      1: return CW'($urandom_range(25000, 33000));
      2: return CW'($urandom_range(12000, 23000));
      default: return CW'($urandom_range(17000, 30000));
    endcase
  endfunction

  task automatic plan_count(input logic [CW-1:0] cnt);
    plan_word_t w;
    w.kind  = PW_COUNT;
    w.count = cnt;
    w.index = '0;
    w.value = '0;
    frame_plan.push_back(w);
  endtask

  task automatic plan_setting(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    plan_word_t w;
    w.kind  = PW_SETTING;
    w.count = '0;
    w.index = idx;
    w.value = val;
    frame_plan.push_back(w);
  endtask

  task automatic plan_settle();
    plan_word_t w;
    w.kind  = PW_SETTLE;
    w.count = '0;
    w.index = '0;
    w.value = '0;
    frame_plan.push_back(w);
  endtask

  // Stimulus plan and end of run
  initial begin
    logic [CW-1:0] directed[23];
    logic [7:0]    lo_set[9];
    logic [7:0]    hi_set[9];
    frame_ch.valid      = 1'b0;
    frame_ch.edge_count = '0;
    result_ch.ready     = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    tuned_upper         = {UPPER_RST_INT, {FB{1'b0}}};
    bound_min           = MIN_UPPER_RST;
    bound_max           = MAX_UPPER_RST;

    // Directed: field extremes and every breakpoint, under reset bounds
    directed = '{0, 20'hFFFFF, 17999, 18000, 18001, 20000, 21000, 21001, 21999,
                 22000, 22001, 23000, 24000, 24500, 25000, 25001, 26000, 26001,
                 27000, 28999, 29000, 29001, 20'h80000};
    foreach (directed[i]) plan_count(directed[i]);
    plan_settle();

    // Bound settings: wide open, pinned high, pinned low, crossed, narrow, crossed, then random
    lo_set = '{0, 255, 0, 200, 100, 255, 0, 0, 0};
    hi_set = '{255, 255, 0, 50, 100, 0, 0, 0, 0};
    for (int p = 6; p < 9; p++) begin
      lo_set[p] = 8'($urandom_range(0, 120));
      hi_set[p] = 8'($urandom_range(130, 255));
    end
    lo_set[8] = 8'($urandom_range(0, 255));

    for (int p = 0; p < 9; p++) begin
      plan_setting(REG_MIN_UPPER, lo_set[p]);
      plan_setting(REG_MAX_UPPER, hi_set[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        plan_count(draw_count(p % 3));
        if ($urandom_range(0, 39) == 0) plan_settle();
      end
    end

    while (frame_plan.size() != 0 || frame_ch.valid) @(posedge clk);
    while (thresholds_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed && thresholds_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Driver: count words and bound writes from the plan
  always @(posedge clk) begin
    logic    hold;
    logic    nxt_valid;
    logic    nxt_we;
    if (rst) begin
      frame_ch.valid <= 1'b0;
      cfg_we         <= 1'b0;
      tx_gap         = 0;
    end else begin
      hold   = frame_ch.valid && !frame_ch.ready;
      nxt_we = 1'b0;
      if (frame_ch.valid && frame_ch.ready) begin
        thresholds_due.push_back(next_thresholds(frame_ch.edge_count));
        tx_gap = draw_wait(tx_burst);
      end
      nxt_valid = hold;
      if (!hold) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (frame_plan.size() != 0) begin
          case (frame_plan[0].kind)
            PW_COUNT: begin
              nxt_valid           = 1'b1;
              frame_ch.edge_count <= frame_plan[0].count;
              void'(frame_plan.pop_front());
            end
            PW_SETTING: begin
              // bounds only change with the tuner drained
              if (thresholds_due.size() == 0) begin
                nxt_we    = 1'b1;
                cfg_index <= frame_plan[0].index;
                cfg_data  <= frame_plan[0].value;
                if (frame_plan[0].index == REG_MIN_UPPER) bound_min = frame_plan[0].value;
                else bound_max = frame_plan[0].value;
                void'(frame_plan.pop_front());
              end
            end
            default: begin
              if (thresholds_due.size() == 0) void'(frame_plan.pop_front());
            end
          endcase
        end
      end
      frame_ch.valid <= nxt_valid;
      cfg_we         <= nxt_we;
    end
  end

  // Monitor: random stalls, each result word against the oldest prediction
  always @(posedge clk) begin
    thresholds_t want;
    if (rst) begin
      rx_stall        = 0;
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (thresholds_due.size() == 0) begin
          $error("unexpected result word: upper_threshold %0d", result_ch.upper_threshold);
          failed = 1'b1;
        end else begin
          want = thresholds_due.pop_front();
          if (result_ch.upper_threshold !== want.upper) begin
            $error("upper_threshold: expected %0d, got %0d", want.upper,
                   result_ch.upper_threshold);
            failed = 1'b1;
          end
          if (result_ch.lower_threshold !== want.lower) begin
            $error("lower_threshold: expected %0d, got %0d", want.lower,
                   result_ch.lower_threshold);
            failed = 1'b1;
          end
          if (result_ch.adjustment !== want.adj) begin
            $error("adjustment: expected %0d, got %0d", want.adj, result_ch.adjustment);
            failed = 1'b1;
          end
        end
        rx_stall = draw_wait(rx_burst);
      end else if (rx_stall != 0) begin
        rx_stall--;
      end
      result_ch.ready <= (rx_stall == 0);
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready) ||
          cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

@@ fuzzy_edge_threshold_tuner_core.f @@
hw/rtl/fett_pkg.sv
hw/rtl/fett_in_if.sv
hw/rtl/fett_out_if.sv
hw/rtl/fuzzy_edge_threshold_tuner_core.sv
tb/tb_fuzzy_edge_threshold_tuner_core.sv
